// File: rtl/stable_priority_queue_unit_macros.svh
// Assertion macros for the stable priority queue unit.
// Used by the top level; depends on nothing else.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue unit.
// Used by spq_cell, stable_priority_queue_unit and the testbench; depends on nothing.
package spq_pkg;

   localparam int ID_W        = 8;
   localparam int PRIO_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Request codes.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_POP    = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

   // One queue entry.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } spq_slot_type;

   // Commands broadcast to every cell.
   typedef struct packed {
      logic ins;
      logic pop;
   } spq_ctl_type;

endpackage

// File: rtl/spq_cell.sv
// One slot of the sorted queue chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::spq_ctl_type ctl,
   input  spq_pkg::spq_slot_type new_slot,
   input  spq_pkg::spq_slot_type left_slot,
   input  logic                 left_ahead,
   input  spq_pkg::spq_slot_type right_slot,
   input  logic                 slot_valid,
   output spq_pkg::spq_slot_type slot,
   output logic                 ahead
);

   spq_pkg::spq_slot_type slot_ff;
   spq_pkg::spq_slot_type slot_in;

   // The new word belongs at or ahead of this slot when the slot is empty
   // or holds a strictly greater priority value.
   assign ahead = !slot_valid || (new_slot.prio < slot_ff.prio);

   // Insert shifts the tail right, pop shifts everything left.
   always_comb begin
      slot_in = slot_ff;
      if (ctl.ins && ahead) begin
         if (left_ahead) begin
            slot_in = left_slot;
         end else begin
            slot_in = new_slot;
         end
      end else if (ctl.pop) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

// File: rtl/stable_priority_queue_unit.sv
// Top level of the stable priority queue unit: a chain of spq_cell slots and a count.
// Depends on spq_pkg, spq_cell and stable_priority_queue_unit_macros.svh.
//
// Channel   Direction  Handshake       Words
// request   in         start / busy    req_type, req_entry_id, req_priority_req
// response  out        rsp_valid       rsp_status, rsp_head_valid, rsp_head_id, rsp_entry_count
//
// A request is taken at any edge where start is high; busy stays low.
// Its response word appears on the next cycle, marked by rsp_valid for one cycle.
// Every slot compares with the new word in parallel, so one request per cycle.
// Reset clears the count and the strobe; slot contents are not cleared.
// The receiver cannot stall, so no response is ever held back.
`include "stable_priority_queue_unit_macros.svh"

module stable_priority_queue_unit #(
   parameter int DEPTH       = 16,
   parameter int PRIO_LEVELS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [spq_pkg::ID_W-1:0]         req_entry_id,
   input  logic [spq_pkg::PRIO_W-1:0]       req_priority_req,
   output logic                             rsp_valid,
   output logic [spq_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_head_valid,
   output logic [spq_pkg::ID_W-1:0]         rsp_head_id,
   output logic [spq_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         rsp_valid_ff;
   logic [spq_pkg::STATUS_W-1:0] status_ff;
   logic [spq_pkg::STATUS_W-1:0] status_in;

   logic                         accept;
   logic                         is_full;
   logic                         is_empty;
   logic [spq_pkg::PRIO_W-1:0]   prio_sat;
   spq_pkg::spq_ctl_type         ctl;
   spq_pkg::spq_slot_type        new_slot;
   spq_pkg::spq_slot_type        slot_q   [DEPTH];
   logic                         ahead_q  [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Saturate the priority to the top level before it is stored.
   assign prio_sat = ({5'd0, req_priority_req} > 9'(PRIO_LEVELS - 1))
                     ? spq_pkg::PRIO_W'(PRIO_LEVELS - 1) : req_priority_req;

   assign new_slot.id   = req_entry_id;
   assign new_slot.prio = prio_sat;

   // Decode the request into chain commands and a status word.
   always_comb begin
      ctl       = '0;
      status_in = spq_pkg::ST_OK;
      count_in  = count_ff;
      if (accept) begin
         if (req_type == spq_pkg::REQ_INSERT) begin
            if (is_full) begin
               status_in = spq_pkg::ST_FULL;
            end else begin
               ctl.ins  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else if (slot_q[0].id != req_entry_id) begin
               status_in = spq_pkg::ST_MISMATCH;
            end else begin
               ctl.pop  = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   // The chain of slots, head at index 0.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::spq_slot_type left_slot;
      spq_pkg::spq_slot_type right_slot;
      logic                  left_ahead;
      logic                  slot_valid;

      assign slot_valid = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_slot  = new_slot;
         assign left_ahead = 1'b0;
      end else begin : g_body
         assign left_slot  = slot_q[i-1];
         assign left_ahead = ahead_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_slot = '0;
      end else begin : g_inner
         assign right_slot = slot_q[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_slot    (new_slot),
         .left_slot   (left_slot),
         .left_ahead  (left_ahead),
         .right_slot  (right_slot),
         .slot_valid  (slot_valid),
         .slot        (slot_q[i]),
         .ahead       (ahead_q[i])
      );
   end

   // Count and response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // The response shows the queue as it stands after the request.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_head_valid  = !is_empty;
   assign rsp_head_id     = is_empty ? '0 : slot_q[0].id;
   assign rsp_entry_count = spq_pkg::COUNT_OUT_W'(count_ff);

   // Checks on count, strobe, status and ordering.
   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count above depth")
   `SPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid, "response strobe missing")
   `SPQ_ASSERT_NEXT(a_insert_grows, clock, reset, ctl.ins, count_ff == CW'($past(count_ff) + 1'b1) && rsp_status == spq_pkg::ST_OK, "insert did not grow count")
   `SPQ_ASSERT_NOW(a_full_status, clock, reset, rsp_valid && rsp_status == spq_pkg::ST_FULL, is_full, "full status without full queue")
   `SPQ_ASSERT_NOW(a_head_order, clock, reset, count_ff >= CW'(2), slot_q[0].prio <= slot_q[1].prio, "head out of order")

endmodule

// File: verif/stable_priority_queue_unit_tb.sv
// Self-checking testbench for stable_priority_queue_unit: directed and random request words.
// Depends on spq_pkg and the RTL of the unit; needs no files or arguments.
`timescale 1ns / 100ps

module stable_priority_queue_unit_tb;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIO_LEVELS   = 16;
   localparam int RANDOM_WORDS  = 1200;
   localparam int DRAIN_LIMIT   = 200;

   // Expected response word, one per accepted request.
   typedef struct packed {
      logic [spq_pkg::STATUS_W-1:0]    status;
      logic                            head_valid;
      logic [spq_pkg::ID_W-1:0]        head_id;
      logic [spq_pkg::COUNT_OUT_W-1:0] entry_count;
   } response_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_type = spq_pkg::REQ_INSERT;
   logic [spq_pkg::ID_W-1:0]        req_entry_id = '0;
   logic [spq_pkg::PRIO_W-1:0]      req_priority_req = '0;
   logic                            rsp_valid;
   logic [spq_pkg::STATUS_W-1:0]    rsp_status;
   logic                            rsp_head_valid;
   logic [spq_pkg::ID_W-1:0]        rsp_head_id;
   logic [spq_pkg::COUNT_OUT_W-1:0] rsp_entry_count;

   // Shadow copy of the queue contents, slot 0 is the head.
   logic [spq_pkg::ID_W-1:0]   shadow_ids   [QUEUE_DEPTH];
   logic [spq_pkg::PRIO_W-1:0] shadow_prios [QUEUE_DEPTH];
   int                         shadow_count = 0;

   response_word_type pending_responses[$];
   int                error_count = 0;
   int                words_sent = 0;
   int                status_tally[4] = '{0, 0, 0, 0};
   int                peak_count = 0;
   bit                no_idle = 1'b0;

   stable_priority_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_entry_id     (req_entry_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_head_valid   (rsp_head_valid),
      .rsp_head_id      (rsp_head_id),
      .rsp_entry_count  (rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Prints one mismatch line and counts it.
   task automatic flag_error(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // Applies one request to the shadow queue and returns the response it should produce.
   function automatic response_word_type apply_request(input logic kind,
                                                       input logic [spq_pkg::ID_W-1:0] id,
                                                       input logic [spq_pkg::PRIO_W-1:0] prio_in);
      logic [spq_pkg::PRIO_W-1:0] prio;
      int                         pos;
      int                         k;
      response_word_type          rsp;
      prio = (int'(prio_in) > PRIO_LEVELS - 1) ? spq_pkg::PRIO_W'(PRIO_LEVELS - 1) : prio_in;
      rsp.status = spq_pkg::ST_OK;
      if (kind == spq_pkg::REQ_INSERT) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            rsp.status = spq_pkg::ST_FULL;
         end else begin
            // New entry goes behind every entry of equal or lower priority value.
            pos = 0;
            while (pos < shadow_count && shadow_prios[pos] <= prio) pos++;
            for (k = shadow_count; k > pos; k--) begin
               shadow_ids[k]   = shadow_ids[k-1];
               shadow_prios[k] = shadow_prios[k-1];
            end
            shadow_ids[pos]   = id;
            shadow_prios[pos] = prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            rsp.status = spq_pkg::ST_EMPTY;
         end else if (shadow_ids[0] != id) begin
            rsp.status = spq_pkg::ST_MISMATCH;
         end else begin
            for (k = 0; k + 1 < shadow_count; k++) begin
               shadow_ids[k]   = shadow_ids[k+1];
               shadow_prios[k] = shadow_prios[k+1];
            end
            shadow_count--;
         end
      end
      rsp.head_valid  = (shadow_count != 0);
      rsp.head_id     = (shadow_count != 0) ? shadow_ids[0] : '0;
      rsp.entry_count = spq_pkg::COUNT_OUT_W'(shadow_count);
      return rsp;
   endfunction

   // Drives one request word after a random gap (none when no_idle is set) and returns at the edge that accepts it.
   task automatic send_word(input logic kind, input logic [spq_pkg::ID_W-1:0] id,
                            input logic [spq_pkg::PRIO_W-1:0] prio);
      int unsigned       gap;
      response_word_type want;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_type         <= kind;
      req_entry_id     <= id;
      req_priority_req <= prio;
      do @(posedge clock); while (busy);
      want = apply_request(kind, id, prio);
      pending_responses.push_back(want);
      status_tally[want.status]++;
      words_sent++;
      if (shadow_count > peak_count) peak_count = shadow_count;
   endtask

   // Holds the sender off until every outstanding response has come back.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   // Pops the head with its own id, so the pop always succeeds.
   task automatic pop_head();
      send_word(spq_pkg::REQ_POP, shadow_ids[0], spq_pkg::PRIO_W'($urandom_range(0, 15)));
   endtask

   // Checks each response word against the oldest expectation.
   always @(posedge clock) begin
      response_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            flag_error("response word with no request outstanding");
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status)
               flag_error($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_head_valid !== want.head_valid)
               flag_error($sformatf("head_valid %0b, expected %0b",
                                    rsp_head_valid, want.head_valid));
            if (rsp_head_id !== want.head_id)
               flag_error($sformatf("head_id 0x%02h, expected 0x%02h",
                                    rsp_head_id, want.head_id));
            if (rsp_entry_count !== want.entry_count)
               flag_error($sformatf("entry_count %0d, expected %0d",
                                    rsp_entry_count, want.entry_count));
         end
      end
   end

   // Pops on an empty queue with the extreme ids.
   task automatic test_empty_pops();
      send_word(spq_pkg::REQ_POP, 8'h00, 4'h0);
      send_word(spq_pkg::REQ_POP, 8'hFF, 4'hF);
   endtask

   // Priority ordering, first-in first-out among ties, and a pop with the wrong id.
   task automatic test_stable_order();
      send_word(spq_pkg::REQ_INSERT, 8'hFF, 4'hF);
      send_word(spq_pkg::REQ_INSERT, 8'h00, 4'h0);
      send_word(spq_pkg::REQ_INSERT, 8'h5A, 4'h7);
      send_word(spq_pkg::REQ_INSERT, 8'hA5, 4'h0);
      send_word(spq_pkg::REQ_POP, 8'hA5, 4'h0);
      send_word(spq_pkg::REQ_POP, 8'h00, 4'hF);
   endtask

   // Fills the queue to the brim, then inserts that must be dropped.
   task automatic test_full_drop();
      int n;
      n = 0;
      while (shadow_count < QUEUE_DEPTH) begin
         send_word(spq_pkg::REQ_INSERT, 8'(8'h10 + n), 4'(n % 3 * 5));
         n++;
      end
      send_word(spq_pkg::REQ_INSERT, 8'hFF, 4'hF);
      send_word(spq_pkg::REQ_INSERT, 8'h00, 4'h0);
   endtask

   // Random traffic in phases that lean toward filling or draining the queue.
   task automatic test_random_churn(input int count);
      bit                         fill_bias;
      logic [spq_pkg::PRIO_W-1:0] prio_mask;
      logic [spq_pkg::PRIO_W-1:0] prio;
      logic [spq_pkg::ID_W-1:0]   id;
      int                         i;
      fill_bias = 1'b0;
      prio_mask = 4'hF;
      for (i = 0; i < count; i++) begin
         // New phase every 40 words; sometimes pause for all responses first.
         if (i % 40 == 0) begin
            if (i != 0) fill_bias = ~fill_bias;
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
               0: prio_mask = 4'h0;
               1: prio_mask = 4'h1;
               2: prio_mask = 4'h3;
               default: prio_mask = 4'hF;
            endcase
            if ($urandom_range(0, 4) == 0) wait_for_drain();
         end
         prio = spq_pkg::PRIO_W'($urandom_range(0, 15)) & prio_mask;
         if ($urandom_range(0, 1) == 1) prio = ~prio;
         id = spq_pkg::ID_W'($urandom_range(0, 255));
         if ($urandom_range(0, 3) < (fill_bias ? 3 : 1)) begin
            send_word(spq_pkg::REQ_INSERT, id, prio);
         end else if (shadow_count != 0 && $urandom_range(0, 4) != 0) begin
            pop_head();
         end else if (shadow_count != 0) begin
            // Wrong id: differs from the head in at least one bit.
            send_word(spq_pkg::REQ_POP,
                      shadow_ids[0] ^ spq_pkg::ID_W'($urandom_range(1, 255)), prio);
         end else begin
            send_word(spq_pkg::REQ_POP, id, prio);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_stable_order();
      wait_for_drain();
      test_full_drop();
      wait_for_drain();
      test_random_churn(RANDOM_WORDS);

      // Let the last responses come back, then watch for strays.
      start <= 1'b0;
      waited = 0;
      while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (pending_responses.size() != 0)
         flag_error($sformatf("%0d responses never arrived", pending_responses.size()));

      $display("Sent %0d requests: %0d ok, %0d dropped when full, %0d pops on empty, %0d id mismatches.",
               words_sent, status_tally[spq_pkg::ST_OK], status_tally[spq_pkg::ST_FULL],
               status_tally[spq_pkg::ST_EMPTY], status_tally[spq_pkg::ST_MISMATCH]);
      $display("Peak occupancy %0d of %0d entries, %0d mismatching fields.",
               peak_count, QUEUE_DEPTH, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("Timeout waiting on the unit.");
      $display("Regression FAIL");
      $finish;
   end

endmodule
